/* sv/v3alu_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// v3alu_pkg : shared types and constants for the vector ALU
// Opcodes, word layouts, queue item and pipeline token, saturation helpers.
// ============================================================================
package v3alu_pkg;

  localparam logic [3:0] OPC_ADD    = 4'd0;
  localparam logic [3:0] OPC_SUB    = 4'd1;
  localparam logic [3:0] OPC_CROSS  = 4'd2;
  localparam logic [3:0] OPC_NEG    = 4'd3;
  localparam logic [3:0] OPC_SCALE  = 4'd4;
  localparam logic [3:0] OPC_DOT    = 4'd5;
  localparam logic [3:0] OPC_MAGSQ  = 4'd6;
  localparam logic [3:0] OPC_MAG    = 4'd7;
  localparam logic [3:0] OPC_DISTSQ = 4'd8;
  localparam logic [3:0] OPC_DIST   = 4'd9;
  localparam logic [3:0] OPC_UNIT   = 4'd10;

  localparam int IN_W  = 232;  // 228 field bits, padded to bytes
  localparam int OUT_W = 152;  // 147 field bits, padded to bytes

  localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

  // decoded word handed from front to back
  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] vres;   // finished vector result for simple ops
    logic             sat;
    logic [5:0][31:0] mx;     // multiplier operands
    logic [5:0][31:0] my;
  } v3alu_item_t;

  // word traveling down the back pipeline
  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] vres;
    logic [48:0]      scalar;
    logic             sat;
    logic             zl;
    logic [2:0][31:0] ax;
  } v3alu_tok_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > S32_MAX_W) return 32'h7FFF_FFFF;
    if (v < S32_MIN_W) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > S32_MAX_W) || (v < S32_MIN_W);
  endfunction

endpackage

/* sv/v3alu_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// v3alu_front : input stage
// Takes a word, does the add/sub/negate/difference work, picks multiplier
// operands for the back end and registers the decoded word.
// ============================================================================
module v3alu_front import v3alu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output v3alu_item_t      out_item
);

  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [31:0] sf;
  logic signed [65:0] s_add [3];
  logic signed [65:0] s_sub [3];
  logic signed [65:0] s_neg [3];
  logic [3:0]         op;
  v3alu_item_t        item_nxt;
  v3alu_item_t        item_r;
  logic               v_r;
  logic               adv;

  assign op = in_data[3:0];
  assign sf = $signed(in_data[227:196]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i]     = $signed(in_data[4 + 32*i +: 32]);
      b[i]     = $signed(in_data[100 + 32*i +: 32]);
      s_add[i] = 66'(a[i]) + 66'(b[i]);
      s_sub[i] = 66'(a[i]) - 66'(b[i]);
      s_neg[i] = -66'(a[i]);
    end
  end

  always_comb begin
    item_nxt    = '0;
    item_nxt.op = op;
    case (op)
      OPC_ADD: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.vres[i] = sat32(s_add[i]);
          item_nxt.sat     = item_nxt.sat | ovf32(s_add[i]);
        end
      end
      OPC_SUB: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.vres[i] = sat32(s_sub[i]);
          item_nxt.sat     = item_nxt.sat | ovf32(s_sub[i]);
        end
      end
      OPC_NEG: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.vres[i] = sat32(s_neg[i]);
          item_nxt.sat     = item_nxt.sat | ovf32(s_neg[i]);
        end
      end
      OPC_CROSS: begin
        item_nxt.mx[0] = a[1]; item_nxt.my[0] = b[2];
        item_nxt.mx[1] = a[2]; item_nxt.my[1] = b[1];
        item_nxt.mx[2] = a[2]; item_nxt.my[2] = b[0];
        item_nxt.mx[3] = a[0]; item_nxt.my[3] = b[2];
        item_nxt.mx[4] = a[0]; item_nxt.my[4] = b[1];
        item_nxt.mx[5] = a[1]; item_nxt.my[5] = b[0];
      end
      OPC_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.mx[i] = a[i];
          item_nxt.my[i] = sf;
        end
      end
      OPC_DOT: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.mx[i] = a[i];
          item_nxt.my[i] = b[i];
        end
      end
      OPC_MAGSQ, OPC_MAG: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.mx[i] = a[i];
          item_nxt.my[i] = a[i];
        end
      end
      OPC_UNIT: begin
        // zero-length input passes through unchanged
        for (int i = 0; i < 3; i++) begin
          item_nxt.mx[i]   = a[i];
          item_nxt.my[i]   = a[i];
          item_nxt.vres[i] = a[i];
        end
      end
      OPC_DISTSQ, OPC_DIST: begin
        for (int i = 0; i < 3; i++) begin
          item_nxt.mx[i] = sat32(s_sub[i]);
          item_nxt.my[i] = sat32(s_sub[i]);
          item_nxt.sat   = item_nxt.sat | ovf32(s_sub[i]);
        end
      end
      default: begin
        item_nxt = '0;
      end
    endcase
  end

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

/* sv/v3alu_fifo.sv */
`timescale 1ns / 1ps
// ============================================================================
// v3alu_fifo : two-entry queue between front and back
// Lets the front keep taking words while the back end is stalled.
// ============================================================================
module v3alu_fifo import v3alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  v3alu_item_t push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output v3alu_item_t pop_item
);

  v3alu_item_t mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* sv/v3alu_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// v3alu_back : execution pipeline
// Products, sums, a bit-per-stage square root, a bit-per-stage reciprocal,
// the unit-vector multiply and the output register, all under one stall.
// ============================================================================
module v3alu_back import v3alu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  v3alu_item_t       in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0][31:0]  out_vec,
  output logic [48:0]       out_scalar,
  output logic              out_zl,
  output logic              out_sat
);

  localparam int SQ_N = 32;
  localparam int DV_N = 33;

  logic adv;
  logic o_v_r;

  assign adv      = !o_v_r || out_ready;
  assign in_ready = adv;

  // ---- stage 1: products
  logic               m1_v_r;
  v3alu_item_t        m1_it_r;
  logic signed [63:0] m1_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (adv) m1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_it_r <= in_item;
      for (int k = 0; k < 6; k++) begin
        m1_p_r[k] <= $signed(in_item.mx[k]) * $signed(in_item.my[k]);
      end
    end
  end

  // ---- stage 2: sums and cross / scale finish
  logic signed [65:0] sum3;
  logic signed [64:0] cdif [3];
  logic signed [65:0] vsh  [3];
  v3alu_tok_t         s2_nxt;

  always_comb begin
    sum3   = 66'(m1_p_r[0]) + 66'(m1_p_r[1]) + 66'(m1_p_r[2]);
    s2_nxt = '0;
    s2_nxt.op   = m1_it_r.op;
    s2_nxt.vres = m1_it_r.vres;
    s2_nxt.sat  = m1_it_r.sat;
    s2_nxt.zl   = (sum3[63:0] == 64'd0);
    for (int i = 0; i < 3; i++) begin
      s2_nxt.ax[i] = m1_it_r.mx[i];
      cdif[i]      = 65'(m1_p_r[2*i]) - 65'(m1_p_r[2*i+1]);
      vsh[i]       = '0;
    end
    case (m1_it_r.op)
      OPC_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          vsh[i]         = 66'(cdif[i] >>> 16);
          s2_nxt.vres[i] = sat32(vsh[i]);
          s2_nxt.sat     = s2_nxt.sat | ovf32(vsh[i]);
        end
      end
      OPC_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          vsh[i]         = 66'(m1_p_r[i] >>> 16);
          s2_nxt.vres[i] = sat32(vsh[i]);
          s2_nxt.sat     = s2_nxt.sat | ovf32(vsh[i]);
        end
      end
      OPC_DOT: begin
        s2_nxt.scalar = 49'(sum3 >>> 16);
      end
      OPC_MAGSQ, OPC_DISTSQ: begin
        s2_nxt.scalar = {1'b0, sum3[63:16]};
      end
      default: begin
        s2_nxt.scalar = '0;
      end
    endcase
  end

  // ---- square root, one result bit per stage
  logic        sq_v_r    [SQ_N+1];
  v3alu_tok_t  sq_tok_r  [SQ_N+1];
  logic [63:0] sq_rem_r  [SQ_N+1];
  logic [31:0] sq_root_r [SQ_N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (adv) sq_v_r[0] <= m1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_tok_r[0]  <= s2_nxt;
      sq_rem_r[0]  <= sum3[63:0];
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam int B = SQ_N - 1 - k;
    logic [64:0] trial;
    logic        ge;
    logic [63:0] rem_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      trial    = (65'(sq_root_r[k]) << (B + 1)) + (65'(1) << (2 * B));
      ge       = ({1'b0, sq_rem_r[k]} >= trial);
      rem_nxt  = ge ? 64'({1'b0, sq_rem_r[k]} - trial) : sq_rem_r[k];
      root_nxt = ge ? (sq_root_r[k] | (32'(1) << B)) : sq_root_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (adv) sq_v_r[k+1] <= sq_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_tok_r[k+1]  <= sq_tok_r[k];
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
      end
    end
  end

  // ---- reciprocal 2^32 / root, one quotient bit per stage
  logic        dv_v_r   [DV_N+1];
  v3alu_tok_t  dv_tok_r [DV_N+1];
  logic [31:0] dv_m_r   [DV_N+1];
  logic [31:0] dv_rem_r [DV_N+1];
  logic [32:0] dv_q_r   [DV_N+1];
  v3alu_tok_t  dv0_nxt;

  always_comb begin
    dv0_nxt = sq_tok_r[SQ_N];
    if (sq_tok_r[SQ_N].op == OPC_MAG || sq_tok_r[SQ_N].op == OPC_DIST) begin
      dv0_nxt.scalar = {17'd0, sq_root_r[SQ_N]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= sq_v_r[SQ_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_tok_r[0] <= dv0_nxt;
      dv_m_r[0]   <= sq_root_r[SQ_N];
      dv_rem_r[0] <= '0;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    localparam int QB = DV_N - 1 - j;
    logic [32:0] rs;
    logic        ge;
    logic [31:0] rem_nxt;
    logic [32:0] q_nxt;

    always_comb begin
      rs      = {dv_rem_r[j], (j == 0) ? 1'b1 : 1'b0};
      ge      = (rs >= {1'b0, dv_m_r[j]});
      rem_nxt = ge ? 32'(rs - {1'b0, dv_m_r[j]}) : rs[31:0];
      q_nxt   = ge ? (dv_q_r[j] | (33'(1) << QB)) : dv_q_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (adv) dv_v_r[j+1] <= dv_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_tok_r[j+1] <= dv_tok_r[j];
        dv_m_r[j+1]   <= dv_m_r[j];
        dv_rem_r[j+1] <= rem_nxt;
        dv_q_r[j+1]   <= q_nxt;
      end
    end
  end

  // ---- unit-vector multiply
  logic               mu_v_r;
  v3alu_tok_t         mu_tok_r;
  logic signed [65:0] mu_p_r [3];
  logic signed [33:0] qs;

  assign qs = $signed({1'b0, dv_q_r[DV_N]});

  always_ff @(posedge clk) begin
    if (!rst_n) mu_v_r <= 1'b0;
    else if (adv) mu_v_r <= dv_v_r[DV_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_tok_r <= dv_tok_r[DV_N];
      for (int i = 0; i < 3; i++) begin
        mu_p_r[i] <= 66'($signed(dv_tok_r[DV_N].ax[i])) * 66'(qs);
      end
    end
  end

  // ---- finish and output register
  v3alu_tok_t         fin_nxt;
  v3alu_tok_t         o_tok_r;
  logic signed [65:0] ush [3];

  always_comb begin
    fin_nxt = mu_tok_r;
    for (int i = 0; i < 3; i++) begin
      ush[i] = mu_p_r[i] >>> 16;
    end
    fin_nxt.zl = 1'b0;
    if (mu_tok_r.op == OPC_UNIT) begin
      fin_nxt.zl = mu_tok_r.zl;
      if (!mu_tok_r.zl) begin
        for (int i = 0; i < 3; i++) begin
          fin_nxt.vres[i] = sat32(ush[i]);
          fin_nxt.sat     = fin_nxt.sat | ovf32(ush[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (adv) o_v_r <= mu_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_tok_r <= fin_nxt;
    end
  end

  assign out_valid  = o_v_r;
  assign out_vec    = o_tok_r.vres;
  assign out_scalar = o_tok_r.scalar;
  assign out_zl     = o_tok_r.zl;
  assign out_sat    = o_tok_r.sat;

endmodule

/* sv/vec3_alu_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// vec3_alu_top : three-component fixed-point vector ALU
// Q16.16 vector operations with saturated vector and Q32.16 scalar results.
// ============================================================================
// Usage:
//   Input words arrive on in_tvalid/in_tready/in_tdata: an opcode, vectors
//   a and b and a scale factor. Each word yields exactly one result word on
//   out_tvalid/out_tready/out_tdata, in order.
//   A word is taken at any clock edge with tvalid and tready both high.
// Throughput: one word per cycle, sustained, with a ready receiver.
// Path: the square root (32 stages, one root bit each) and the reciprocal
//   2^32/root (33 stages, one quotient bit each) are passed by every word,
//   whatever its opcode, along with the front, product, sum, unit multiply
//   and output registers.
// Reset: rst_n low (synchronous) empties the pipeline and the queue; no
//   results are pending afterward.
// Stall: when out_tready is low the back pipeline holds; a two-entry queue
//   between front and back keeps in_tready up until the queue and the front
//   register are full, then in_tready drops until out_tready is high again.
// ============================================================================
module vec3_alu_top import v3alu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // opcode[3:0], a_x[35:4], a_y[67:36], a_z[99:68], b_x[131:100],
  // b_y[163:132], b_z[195:164], scale_factor[227:196], zero pad[231:228]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // r_x[31:0], r_y[63:32], r_z[95:64], scalar_out[144:96],
  // zero_length[145], saturated[146], zero pad[151:147]
  output logic [OUT_W-1:0] out_tdata
);

  logic             fr_valid;
  logic             fr_ready;
  v3alu_item_t      fr_item;
  logic             q_valid;
  logic             q_ready;
  v3alu_item_t      q_item;
  logic [2:0][31:0] res_vec;
  logic [48:0]      res_scalar;
  logic             res_zl;
  logic             res_sat;

  // front: decode and simple arithmetic
  v3alu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  // queue decoupling front from back
  v3alu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // back: multiply, root, reciprocal, finish
  v3alu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_vec    (res_vec),
    .out_scalar (res_scalar),
    .out_zl     (res_zl),
    .out_sat    (res_sat)
  );

  assign out_tdata = {5'd0, res_sat, res_zl, res_scalar,
                      res_vec[2], res_vec[1], res_vec[0]};

endmodule

/* tb/vec3_alu_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// vec3_alu_top_test : self-checking bench for the vector ALU
// Drives random and directed opcode words with random idling on both sides,
// predicts each result word in fixed point and compares field by field.
// ============================================================================
module vec3_alu_top_test;
  import v3alu_pkg::*;

  // Expected result word, one per accepted input word.
  typedef struct {
    logic [31:0] rx, ry, rz;
    logic [48:0] scalar;
    logic        zl, sat;
  } alu_res_t;

  int errors = 0;

  // Prints one line per mismatch and bumps the error count.
  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Fixed-point predictor. Products and sums are carried at 128 bits, so
  // nothing intermediate can overflow.
  // ---------------------------------------------------------------------------
  function automatic logic signed [127:0] fl16(input logic signed [127:0] v);
    return v >>> 16;  // arithmetic shift is floor
  endfunction

  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic s);
    if (v > 128'sd2147483647) begin s = 1; return 32'h7FFF_FFFF; end
    if (v < -128'sd2147483648) begin s = 1; return 32'h8000_0000; end
    return v[31:0];
  endfunction

  function automatic logic [48:0] clip49(input logic signed [127:0] v, inout logic s);
    if (v > 128'sd281474976710655) begin s = 1; return {1'b0, {48{1'b1}}}; end
    if (v < -128'sd281474976710656) begin s = 1; return {1'b1, 48'd0}; end
    return v[48:0];
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic alu_res_t compute_alu(input logic [IN_W-1:0] w);
    alu_res_t e;
    logic [3:0] op;
    logic signed [127:0] a [3], b [3], d [3], sc, acc, rc;
    logic [127:0] sq, m;
    logic s;
    op = w[3:0];
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(w[4 + 32*i +: 32]);
      b[i] = $signed(w[100 + 32*i +: 32]);
    end
    sc = $signed(w[196 +: 32]);
    e.rx = 0; e.ry = 0; e.rz = 0; e.scalar = 0; e.zl = 0;
    s = 0;
    case (op)
      OPC_ADD: begin
        e.rx = clip32(a[0] + b[0], s); e.ry = clip32(a[1] + b[1], s);
        e.rz = clip32(a[2] + b[2], s);
      end
      OPC_SUB: begin
        e.rx = clip32(a[0] - b[0], s); e.ry = clip32(a[1] - b[1], s);
        e.rz = clip32(a[2] - b[2], s);
      end
      OPC_CROSS: begin
        e.rx = clip32(fl16(a[1] * b[2] - a[2] * b[1]), s);
        e.ry = clip32(fl16(a[2] * b[0] - a[0] * b[2]), s);
        e.rz = clip32(fl16(a[0] * b[1] - a[1] * b[0]), s);
      end
      OPC_NEG: begin
        e.rx = clip32(-a[0], s); e.ry = clip32(-a[1], s); e.rz = clip32(-a[2], s);
      end
      OPC_SCALE: begin
        e.rx = clip32(fl16(a[0] * sc), s); e.ry = clip32(fl16(a[1] * sc), s);
        e.rz = clip32(fl16(a[2] * sc), s);
      end
      OPC_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        e.scalar = clip49(fl16(acc), s);
      end
      OPC_MAGSQ, OPC_MAG: begin
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        e.scalar = clip49((op == OPC_MAGSQ) ? (sq >> 16) : root_floor(sq), s);
      end
      OPC_DISTSQ, OPC_DIST: begin
        for (int i = 0; i < 3; i++) d[i] = $signed(clip32(a[i] - b[i], s));
        sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        e.scalar = clip49((op == OPC_DISTSQ) ? (sq >> 16) : root_floor(sq), s);
      end
      OPC_UNIT: begin
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        if (sq == 0) begin
          // zero-length vector passes through unchanged
          e.zl = 1;
          e.rx = a[0][31:0]; e.ry = a[1][31:0]; e.rz = a[2][31:0];
        end else begin
          m = root_floor(sq);
          rc = (128'd1 << 32) / m;
          e.rx = clip32(fl16(a[0] * rc), s); e.ry = clip32(fl16(a[1] * rc), s);
          e.rz = clip32(fl16(a[2] * rc), s);
        end
      end
      default: ;  // unused opcodes give all zeros
    endcase
    e.sat = s;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: holds the expected results in order.
  // ---------------------------------------------------------------------------
  class alu_scoreboard;
    alu_res_t pending[$];

    function void note_input(input logic [IN_W-1:0] w);
      pending.push_back(compute_alu(w));
    endfunction

    task check_result(input logic [OUT_W-1:0] w);
      alu_res_t e;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (w[31:0] !== e.rx) report($sformatf("r_x %h exp %h", w[31:0], e.rx));
      if (w[63:32] !== e.ry) report($sformatf("r_y %h exp %h", w[63:32], e.ry));
      if (w[95:64] !== e.rz) report($sformatf("r_z %h exp %h", w[95:64], e.rz));
      if (w[144:96] !== e.scalar)
        report($sformatf("scalar %h exp %h", w[144:96], e.scalar));
      if (w[145] !== e.zl) report($sformatf("zero_length %b exp %b", w[145], e.zl));
      if (w[146] !== e.sat) report($sformatf("saturated %b exp %b", w[146], e.sat));
    endtask
  endclass

  alu_scoreboard sb = new();

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [OUT_W-1:0] out_tdata;
  bit quiet = 0;      // no idling in the last part of the run
  bit stim_done = 0;
  int idle_cnt = 0;
  localparam int WDOG_LIMIT = 2000;  // pipeline latency plus stalls, with margin

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  vec3_alu_top u_top (.*);

  // Monitor: accept points sampled on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("vec3_alu_top test failed");
      $finish;
    end
  end

  // Receiver: random bursts of stall, none once quiet.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 5);
        repeat (n) @(negedge clk);
      end
      out_tready <= 1;
      n = $urandom_range(1, 8);
      repeat (n) @(negedge clk);
    end
  end

  // Present one word and hold it until taken; sometimes inserts a random gap first, never once quiet.
  task automatic send_word(input logic [IN_W-1:0] w);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(1, 5);
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;  // about +-2.0
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [IN_W-1:0] make_word(input logic [3:0] op, input int mode);
    logic [IN_W-1:0] w;
    w = '0;
    w[3:0] = op;
    for (int i = 0; i < 7; i++) begin
      w[4 + 32*i +: 32] = rand_comp((mode < 0) ? $urandom_range(0, 5) : mode);
    end
    return w;
  endfunction

  initial begin
    logic [IN_W-1:0] w;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    // Directed: every opcode at the extremes, plus the special cases.
    for (int op = 0; op <= 10; op++) send_word(make_word(4'(op), 1));
    for (int op = 0; op <= 10; op++) send_word(make_word(4'(op), 2));
    send_word(make_word(OPC_UNIT, 3));      // zero-length unit vector
    w = make_word(OPC_NEG, 3);
    w[4 +: 32] = 32'h8000_0000;             // negate of most negative
    send_word(w);
    send_word(make_word(4'd15, 0));         // unused opcode
    // Random part; the tail runs with no idling.
    for (int k = 0; k < 1800; k++) begin
      if (k == 1600) quiet = 1;
      send_word(make_word(($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                       : 4'($urandom_range(0, 10)), -1));
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  // End of run: drain, then keep watching for stray result words.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("vec3_alu_top test passed");
    else $display("vec3_alu_top test failed");
    $finish;
  end

endmodule
